@@ src/fdma_pkg.sv @@
package fdma_pkg;

    localparam int FIELD_W      = 32;
    localparam int SQRT_W       = 24;
    localparam int ISQRT_STAGES = 24;
    localparam int TAYLOR_TERMS = 14;
    localparam int EXP_STAGES   = 6 + 2 * (TAYLOR_TERMS - 1);
    localparam int AVG_STAGES   = 5;
    localparam int FRONT_STAGES = ISQRT_STAGES + EXP_STAGES;
    localparam int LATENCY      = FRONT_STAGES + AVG_STAGES;

    localparam logic signed [55:0] LN2_Q40  = 56'sh00_00B1_7217_F7D2;
    localparam logic signed [55:0] ARG_HIGH = 56'sh00_0C00_0000_0000;
    localparam logic signed [55:0] ARG_LOW  = -56'sh00_1100_0000_0000;
    localparam logic signed [16:0] K_RECIP  = 17'sd23637;
    localparam logic [34:0]        DIV3_MAGIC = 35'd22906492246;

    localparam logic [1:0] REGION_ONE = 2'd1;
    localparam logic [1:0] REGION_TWO = 2'd2;

    typedef enum logic [1:0] {
        CFG_MOB_ONE = 2'd0,
        CFG_MOB_TWO = 2'd1,
        CFG_GAIN    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } node_exp_t;

endpackage

@@ src/fdma_isqrt.sv @@
module fdma_isqrt (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [fdma_pkg::FIELD_W-1:0]   field,
    output logic [fdma_pkg::SQRT_W-1:0]    root
);
    import fdma_pkg::*;

    localparam int RW = FIELD_W + 16;

    logic [RW-1:0] rem_in  [ISQRT_STAGES];
    logic [RW-1:0] res_in  [ISQRT_STAGES];
    logic [RW-1:0] rem_reg [ISQRT_STAGES];
    logic [RW-1:0] res_reg [ISQRT_STAGES];

    assign rem_in[0] = {field, 16'b0};
    assign res_in[0] = '0;

    for (genvar i = 0; i < ISQRT_STAGES; i++) begin : g_step
        localparam logic [RW-1:0] BIT_VAL = {{(RW-1){1'b0}}, 1'b1} << (RW - 2 - 2 * i);
        logic [RW-1:0] trial;
        logic [RW-1:0] rem_next;
        logic [RW-1:0] res_next;

        if (i > 0) begin : g_link
            assign rem_in[i] = rem_reg[i-1];
            assign res_in[i] = res_reg[i-1];
        end

        always_comb begin
            trial = res_in[i] + BIT_VAL;
            if (rem_in[i] >= trial) begin
                rem_next = rem_in[i] - trial;
                res_next = (res_in[i] >> 1) + BIT_VAL;
            end else begin
                rem_next = rem_in[i];
                res_next = res_in[i] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= rem_next;
                res_reg[i] <= res_next;
            end
        end
    end

    assign root = res_reg[ISQRT_STAGES-1][SQRT_W-1:0];

endmodule

@@ src/fdma_exp.sv @@
module fdma_exp (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [fdma_pkg::SQRT_W-1:0]   root,
    input  logic signed [31:0]            gain,
    output fdma_pkg::node_exp_t           result
);
    import fdma_pkg::*;

    localparam int TS = 2 * (TAYLOR_TERMS - 1);

    typedef struct packed {
        logic [31:0]       r;
        logic [33:0]       sum;
        logic signed [6:0] k;
        logic              hi;
        logic              lo;
    } taylor_ctx_t;

    logic signed [55:0] x_next;
    logic signed [55:0] x_reg;
    logic signed [55:0] x1_reg;
    logic signed [25:0] xt;
    logic signed [42:0] kprod;
    logic signed [7:0]  k1_reg;
    logic               hi1_reg;
    logic               lo1_reg;
    logic signed [55:0] r0_next;
    logic signed [55:0] r2_reg;
    logic signed [7:0]  k2_reg;
    logic               hi2_reg;
    logic               lo2_reg;
    logic signed [55:0] r3_fix;
    logic signed [7:0]  k3_fix;
    logic [31:0]        r3_reg;
    logic signed [6:0]  k3_reg;
    logic               hi3_reg;
    logic               lo3_reg;
    taylor_ctx_t        ctx_reg  [TS+1];
    logic [31:0]        term_reg [TS+1];
    logic [6:0]         up_sh;
    logic [6:0]         dn_sh;
    logic [35:0]        part;
    logic [35:0]        val;
    node_exp_t          result_next;
    node_exp_t          result_reg;

    assign x_next = gain * $signed({1'b0, root});

    assign xt    = x_reg[55:30];
    assign kprod = xt * K_RECIP;

    assign r0_next = x1_reg - k1_reg * LN2_Q40;

    always_comb begin
        if (r2_reg < 0) begin
            r3_fix = r2_reg + LN2_Q40;
            k3_fix = k2_reg - 8'sd1;
        end else if (r2_reg >= LN2_Q40) begin
            r3_fix = r2_reg - LN2_Q40;
            k3_fix = k2_reg + 8'sd1;
        end else begin
            r3_fix = r2_reg;
            k3_fix = k2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg   <= x_next;
            x1_reg  <= x_reg;
            k1_reg  <= kprod[31:24];
            hi1_reg <= (x_reg >= ARG_HIGH);
            lo1_reg <= (x_reg < ARG_LOW);
            r2_reg  <= r0_next;
            k2_reg  <= k1_reg;
            hi2_reg <= hi1_reg;
            lo2_reg <= lo1_reg;
            r3_reg  <= r3_fix[39:8];
            k3_reg  <= k3_fix[6:0];
            hi3_reg <= hi2_reg;
            lo3_reg <= lo2_reg;
            ctx_reg[0].r   <= r3_reg;
            ctx_reg[0].sum <= {2'b01, 32'b0} + {2'b00, r3_reg};
            ctx_reg[0].k   <= k3_reg;
            ctx_reg[0].hi  <= hi3_reg;
            ctx_reg[0].lo  <= lo3_reg;
            term_reg[0]    <= r3_reg;
        end
    end

    for (genvar j = 1; j < TAYLOR_TERMS; j++) begin : g_term
        localparam int N = j + 1;
        localparam int L = $clog2(N);
        localparam logic [32:0] MAG = 33'(((64'd1 << (32 + L)) + 64'(N) - 64'd1) / 64'(N));
        logic [63:0] mprod;
        logic [64:0] dprod;
        logic [31:0] quot;

        assign mprod = term_reg[2*j-2] * ctx_reg[2*j-2].r;
        assign dprod = term_reg[2*j-1] * MAG;
        assign quot  = 32'(dprod >> (32 + L));

        always_ff @(posedge aclk) begin
            if (en) begin
                term_reg[2*j-1] <= mprod[63:32];
                ctx_reg[2*j-1]  <= ctx_reg[2*j-2];
                term_reg[2*j]   <= quot;
                ctx_reg[2*j].r   <= ctx_reg[2*j-1].r;
                ctx_reg[2*j].sum <= ctx_reg[2*j-1].sum + {2'b00, quot};
                ctx_reg[2*j].k   <= ctx_reg[2*j-1].k;
                ctx_reg[2*j].hi  <= ctx_reg[2*j-1].hi;
                ctx_reg[2*j].lo  <= ctx_reg[2*j-1].lo;
            end
        end
    end

    always_comb begin
        up_sh = 7'(ctx_reg[TS].k - 7'sd16);
        dn_sh = 7'(7'sd16 - ctx_reg[TS].k);
        part  = '0;
        if (ctx_reg[TS].k >= 7'sd16) begin
            val = {2'b00, ctx_reg[TS].sum} << up_sh;
        end else begin
            part = {2'b00, ctx_reg[TS].sum} >> (dn_sh - 7'd1);
            val  = (part + 36'd1) >> 1;
        end
        if (ctx_reg[TS].hi) begin
            result_next.value = '1;
            result_next.sat   = 1'b1;
        end else if (ctx_reg[TS].lo) begin
            result_next.value = '0;
            result_next.sat   = 1'b0;
        end else if (val[35:32] != 4'd0) begin
            result_next.value = '1;
            result_next.sat   = 1'b1;
        end else begin
            result_next.value = val[31:0];
            result_next.sat   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

@@ src/fdma_average.sv @@
module fdma_average (
    input  logic                  aclk,
    input  logic                  en,
    input  fdma_pkg::node_exp_t   exp_a,
    input  fdma_pkg::node_exp_t   exp_b,
    input  fdma_pkg::node_exp_t   exp_c,
    input  logic [1:0]            marker,
    input  logic [31:0]           mob_one,
    input  logic [31:0]           mob_two,
    output logic [31:0]           mobility,
    output logic                  region_error,
    output logic                  saturated
);
    import fdma_pkg::*;

    typedef struct packed {
        logic [1:0] marker;
        logic       sat;
    } avg_ctx_t;

    avg_ctx_t    ctx_reg [4];
    logic [33:0] sum_reg;
    logic [51:0] plo_reg;
    logic [51:0] phi_reg;
    logic [68:0] total;
    logic [31:0] mean_reg;
    logic [31:0] mob0;
    logic [63:0] prod_reg;
    logic [64:0] rounded;
    logic [31:0] mobility_next;
    logic        region_error_next;
    logic        saturated_next;
    logic [31:0] mobility_reg;
    logic        region_error_reg;
    logic        saturated_reg;

    assign total = {phi_reg, 17'b0} + {17'b0, plo_reg};

    always_comb begin
        case (ctx_reg[2].marker)
            REGION_ONE: mob0 = mob_one;
            REGION_TWO: mob0 = mob_two;
            default:    mob0 = '0;
        endcase
    end

    assign rounded = {1'b0, prod_reg} + 65'h8000;

    always_comb begin
        case (ctx_reg[3].marker)
            REGION_ONE, REGION_TWO: begin
                region_error_next = 1'b0;
                if (rounded[64:48] != 17'd0) begin
                    mobility_next  = '1;
                    saturated_next = 1'b1;
                end else begin
                    mobility_next  = rounded[47:16];
                    saturated_next = ctx_reg[3].sat;
                end
            end
            default: begin
                mobility_next     = '0;
                region_error_next = 1'b1;
                saturated_next    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= {2'b00, exp_a.value} + {2'b00, exp_b.value}
                     + {2'b00, exp_c.value} + 34'd1;
            ctx_reg[0].marker <= marker;
            ctx_reg[0].sat    <= exp_a.sat | exp_b.sat | exp_c.sat;
            plo_reg  <= sum_reg[16:0] * DIV3_MAGIC;
            phi_reg  <= sum_reg[33:17] * DIV3_MAGIC;
            ctx_reg[1] <= ctx_reg[0];
            mean_reg <= total[67:36];
            ctx_reg[2] <= ctx_reg[1];
            prod_reg <= mob0 * mean_reg;
            ctx_reg[3] <= ctx_reg[2];
            mobility_reg     <= mobility_next;
            region_error_reg <= region_error_next;
            saturated_reg    <= saturated_next;
        end
    end

    assign mobility     = mobility_reg;
    assign region_error = region_error_reg;
    assign saturated    = saturated_reg;

endmodule

@@ src/field_dependent_mobility_average.sv @@
// Pipeline: an accepted input passes the square-root, exponential and averaging stages to the output register.
// Throughput: one element per cycle; the whole pipeline advances together and
// holds while a result waits on the output with m_ready low.
// Reset: aresetn clears all pipeline valid bits and sets the configuration
// registers to mobility 1.0 for both regions and a field gain of zero.
module field_dependent_mobility_average (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_field_node_a,
    input  logic [31:0] s_field_node_b,
    input  logic [31:0] s_field_node_c,
    input  logic [1:0]  s_region_marker,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_mobility,
    output logic        m_region_error,
    output logic        m_saturated,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import fdma_pkg::*;

    logic [31:0]        mob_one_reg;
    logic [31:0]        mob_two_reg;
    logic signed [31:0] gain_reg;
    logic [LATENCY-1:0] vld_reg;
    logic [1:0]         mk_reg [FRONT_STAGES];
    logic               en;
    logic [SQRT_W-1:0]  root_a;
    logic [SQRT_W-1:0]  root_b;
    logic [SQRT_W-1:0]  root_c;
    node_exp_t          exp_a;
    node_exp_t          exp_b;
    node_exp_t          exp_c;

    assign en      = ~vld_reg[LATENCY-1] | m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LATENCY-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mob_one_reg <= 32'h0001_0000;
            mob_two_reg <= 32'h0001_0000;
            gain_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_MOB_ONE: mob_one_reg <= cfg_wdata;
                CFG_MOB_TWO: mob_two_reg <= cfg_wdata;
                CFG_GAIN:    gain_reg    <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LATENCY-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mk_reg[0] <= s_region_marker;
            for (int i = 1; i < FRONT_STAGES; i++) begin
                mk_reg[i] <= mk_reg[i-1];
            end
        end
    end

    fdma_isqrt u_sqrt_a (.aclk(aclk), .en(en), .field(s_field_node_a), .root(root_a));
    fdma_isqrt u_sqrt_b (.aclk(aclk), .en(en), .field(s_field_node_b), .root(root_b));
    fdma_isqrt u_sqrt_c (.aclk(aclk), .en(en), .field(s_field_node_c), .root(root_c));

    fdma_exp u_exp_a (.aclk(aclk), .en(en), .root(root_a), .gain(gain_reg), .result(exp_a));
    fdma_exp u_exp_b (.aclk(aclk), .en(en), .root(root_b), .gain(gain_reg), .result(exp_b));
    fdma_exp u_exp_c (.aclk(aclk), .en(en), .root(root_c), .gain(gain_reg), .result(exp_c));

    fdma_average u_avg (
        .aclk         (aclk),
        .en           (en),
        .exp_a        (exp_a),
        .exp_b        (exp_b),
        .exp_c        (exp_c),
        .marker       (mk_reg[FRONT_STAGES-1]),
        .mob_one      (mob_one_reg),
        .mob_two      (mob_two_reg),
        .mobility     (m_mobility),
        .region_error (m_region_error),
        .saturated    (m_saturated)
    );

endmodule
